FILE: rtl/sha256_pkg.sv
// sha-256 core types, round constants and initial hash values
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out;

    typedef enum logic [1:0] {
        SEL_DATA = 2'd0,
        SEL_MARK = 2'd1,
        SEL_ZERO = 2'd2,
        SEL_LEN  = 2'd3
    } t_byte_sel;

    typedef struct packed {
        logic      put;
        t_byte_sel sel;
        logic      load;
        logic      round;
        logic      update;
        logic      out_next;
        logic      reinit;
    } t_cmd;

    typedef struct packed {
        logic [5:0] fill;
        logic       round_last;
        logic       out_last;
    } t_stat;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [5:0] LAST_POS  = 6'd63;
    localparam logic [5:0] LAST_RND  = 6'd63;
    localparam logic [2:0] LAST_WORD = 3'd7;

    localparam logic [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

FILE: rtl/sha256_ctrl.sv
// sha-256 controller: byte intake, padding, compression sequencing, digest output
module sha256_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  sha256_pkg::t_in    i_in_data,
    input  logic               i_out_ready,
    input  sha256_pkg::t_stat  i_stat,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output sha256_pkg::t_cmd   o_cmd
);
    import sha256_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ROUND  = 5'b00010,
        S_UPDATE = 5'b00100,
        S_PAD    = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_fin, n_fin;
    logic   r_marked, n_marked;
    logic   r_len, n_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fin    <= 1'b0;
            r_marked <= 1'b0;
            r_len    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fin    <= n_fin;
            r_marked <= n_marked;
            r_len    <= n_len;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_fin       = r_fin;
        n_marked    = r_marked;
        n_len       = r_len;
        o_cmd       = '0;
        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = (r_state == S_OUT);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_fin = i_in_data.last;
                    if (i_in_data.has_byte) begin
                        o_cmd.put = 1'b1;
                        o_cmd.sel = SEL_DATA;
                        if (i_stat.fill == LAST_POS) begin
                            o_cmd.load = 1'b1;
                            n_state    = S_ROUND;
                        end else if (i_in_data.last) begin
                            n_state = S_PAD;
                        end
                    end else if (i_in_data.last) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_stat.round_last) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                priority if (!r_fin) begin
                    n_state = S_IDLE;
                end else if (r_len) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_PAD: begin
                o_cmd.put = 1'b1;
                priority if (!r_marked) begin
                    o_cmd.sel = SEL_MARK;
                    n_marked  = 1'b1;
                end else if (r_len || i_stat.fill == LEN_POS) begin
                    o_cmd.sel = SEL_LEN;
                    n_len     = 1'b1;
                end else begin
                    o_cmd.sel = SEL_ZERO;
                end
                if (i_stat.fill == LAST_POS) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ROUND;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    o_cmd.out_next = 1'b1;
                    if (i_stat.out_last) begin
                        o_cmd.reinit = 1'b1;
                        n_fin        = 1'b0;
                        n_marked     = 1'b0;
                        n_len        = 1'b0;
                        n_state      = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/sha256_dp.sv
// sha-256 datapath: block window, message schedule, round unit, hash words
module sha256_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha256_pkg::t_cmd   i_cmd,
    input  logic [7:0]         i_data_byte,
    output sha256_pkg::t_stat  o_stat,
    output sha256_pkg::t_out   o_out
);
    import sha256_pkg::*;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] r_hash [8];
    logic [31:0] r_w    [16];
    logic [31:0] r_v    [8];
    logic [23:0] r_acc;
    logic [5:0]  r_fill;
    logic [63:0] r_count;
    logic [5:0]  r_round;
    logic [2:0]  r_idx;

    logic [7:0]  w_byte;
    logic [63:0] w_len_sh;
    logic [31:0] w_word;
    logic [31:0] w_new;
    logic [31:0] w_s0, w_s1;
    logic [31:0] w_big0, w_big1, w_ch, w_maj, w_t1, w_t2;

    assign w_len_sh = r_count >> {~r_fill[2:0], 3'b000};

    always_comb begin
        unique case (i_cmd.sel)
            SEL_DATA: w_byte = i_data_byte;
            SEL_MARK: w_byte = PAD_MARK;
            SEL_ZERO: w_byte = 8'h00;
            SEL_LEN:  w_byte = w_len_sh[7:0];
            default:  w_byte = 8'h00;
        endcase
    end

    assign w_word = {r_acc, w_byte};

    assign w_s0  = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
    assign w_s1  = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_new = w_s1 + r_w[9] + w_s0 + r_w[0];

    assign w_big1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
    assign w_ch   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign w_t1   = r_v[7] + w_big1 + w_ch + ROUND_K[r_round] + r_w[0];
    assign w_big0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
    assign w_maj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign w_t2   = w_big0 + w_maj;

    // block window doubles as schedule shift line
    always_ff @(posedge i_clk) begin
        if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_new;
        end else if (i_cmd.put) begin
            if (r_fill[1:0] == 2'b11) begin
                for (int i = 0; i < 15; i++) begin
                    r_w[i] <= r_w[i+1];
                end
                r_w[15] <= w_word;
            end else begin
                r_acc <= {r_acc[15:0], w_byte};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_hash[i];
            end
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= HASH_IV[i];
            end
            r_fill  <= '0;
            r_count <= '0;
            r_round <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.put) begin
                r_fill <= r_fill + 6'd1;
                if (i_cmd.sel == SEL_DATA) begin
                    r_count <= r_count + 64'd8;
                end
            end
            if (i_cmd.round) begin
                r_round <= r_round + 6'd1;
            end
            if (i_cmd.update) begin
                for (int i = 0; i < 8; i++) begin
                    r_hash[i] <= r_hash[i] + r_v[i];
                end
            end
            if (i_cmd.out_next) begin
                r_idx <= r_idx + 3'd1;
            end
            if (i_cmd.reinit) begin
                for (int i = 0; i < 8; i++) begin
                    r_hash[i] <= HASH_IV[i];
                end
                r_count <= '0;
                r_idx   <= '0;
            end
        end
    end

    assign o_stat.fill       = r_fill;
    assign o_stat.round_last = (r_round == LAST_RND);
    assign o_stat.out_last   = (r_idx == LAST_WORD);

    assign o_out.digest_word = r_hash[r_idx];
    assign o_out.word_index  = r_idx;
    assign o_out.last_word   = (r_idx == LAST_WORD);

endmodule

FILE: rtl/sha256_hash_core.sv
// sha-256 hash core top level: byte items in, eight digest word items out
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+-----------------------------------------------
//  in      | in  | i_in_valid / o_in_ready   | i_in_data  (data_byte, has_byte, last)
//  out     | out | o_out_valid / i_out_ready | o_out_data (digest_word, word_index, last_word)
//
// a byte item is accepted while idle; a byte that fills the block adds 64 compression rounds
// and a hash update, and no new byte is taken until both are done
// a last item runs one padding byte per cycle plus one or two compressions,
// then offers eight digest words, one per cycle while i_out_ready is high
// one item is in flight at a time: o_in_ready is high only when idle
// synchronous active-low reset restores the initial hash values
module sha256_hash_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sha256_pkg::t_in   i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sha256_pkg::t_out  o_out_data
);
    import sha256_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    sha256_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    sha256_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_data_byte (i_in_data.data_byte),
        .o_stat      (w_stat),
        .o_out       (o_out_data)
    );

endmodule

FILE: rtl/sha256_chk.sv
// sha-256 core port checker and its bind to the top level
module sha256_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input sha256_pkg::t_in   i_in_data,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input sha256_pkg::t_out  o_out_data
);
    import sha256_pkg::*;

    // output item holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output item changed while stalled");

    // no intake while digest is being offered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while digest pending");

    // digest words advance by one per accepted item
    a_word_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.last_word |=>
            o_out_valid && o_out_data.word_index == $past(o_out_data.word_index) + 3'd1)
        else $error("digest word sequence broken");

    // digest ends after the final word
    a_word_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_data.last_word |=> !o_out_valid && o_in_ready)
        else $error("output did not end after final word");

endmodule

bind sha256_hash_core sha256_chk u_chk (.*);
